// ===== hdl/orsft_pkg.sv =====
// ----------------------------------------------------------------------------
// orsft_pkg
// Shared types, constants and helpers for the OOK remote-switch frame
// transmitter.
// ----------------------------------------------------------------------------
package orsft_pkg;

   // Duration counter width; loaded times saturate at its maximum.
   localparam int COUNT_WIDTH = 16;
   localparam logic [31:0] COUNT_MAX = (32'd1 << COUNT_WIDTH) - 32'd1;

   localparam int TIME_WIDTH  = 16;
   localparam int REP_WIDTH   = 4;
   localparam int ID_WIDTH    = 26;
   localparam int RCP_WIDTH   = 4;
   localparam int FRAME_LEN   = 32;
   localparam int BIDX_WIDTH  = 6;
   localparam int CSR_IDX_WIDTH = 3;

   // Register reset values
   localparam logic [TIME_WIDTH-1:0] PULSE_HIGH_RST   = 16'd275;
   localparam logic [TIME_WIDTH-1:0] FIRST_LATCH_RST  = 16'd9900;
   localparam logic [TIME_WIDTH-1:0] SECOND_LATCH_RST = 16'd2674;
   localparam logic [TIME_WIDTH-1:0] ZERO_LOW_RST     = 16'd240;
   localparam logic [TIME_WIDTH-1:0] ONE_LOW_RST      = 16'd1300;
   localparam logic [REP_WIDTH-1:0]  REPEAT_RST       = 4'd4;
   localparam logic [TIME_WIDTH-1:0] GAP_RST          = 16'd10000;

   // Register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PULSE_HIGH   = 3'd0,
      CSR_FIRST_LATCH  = 3'd1,
      CSR_SECOND_LATCH = 3'd2,
      CSR_ZERO_LOW     = 3'd3,
      CSR_ONE_LOW      = 3'd4,
      CSR_REPEAT       = 3'd5,
      CSR_GAP          = 3'd6
   } csr_idx_type;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_LATCH1 = 6'b000010,
      PH_LATCH2 = 6'b000100,
      PH_DATA   = 6'b001000,
      PH_TRAIL  = 6'b010000,
      PH_GAP    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] pulse_high_ticks;
      logic [TIME_WIDTH-1:0] first_latch_low_ticks;
      logic [TIME_WIDTH-1:0] second_latch_low_ticks;
      logic [TIME_WIDTH-1:0] zero_symbol_low_ticks;
      logic [TIME_WIDTH-1:0] one_symbol_low_ticks;
      logic [REP_WIDTH-1:0]  repeat_count;
      logic [TIME_WIDTH-1:0] repeat_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic tx_level;
      logic busy_res;
      logic start_accepted;
   } rsp_type;

   // Zero becomes one tick unless zero is allowed; saturate at the counter max.
   function automatic logic [COUNT_WIDTH-1:0] clamp_len(input logic [TIME_WIDTH-1:0] v,
                                                        input logic zero_ok);
      logic [31:0] ext;
      ext = {{(32-TIME_WIDTH){1'b0}}, v};
      if (!zero_ok && v == '0) begin
         ext = 32'd1;
      end
      if (ext > COUNT_MAX) begin
         ext = COUNT_MAX;
      end
      return ext[COUNT_WIDTH-1:0];
   endfunction

endpackage

// ===== hdl/orsft_csr.sv =====
// ----------------------------------------------------------------------------
// orsft_csr
// Timing and repeat registers, written through the csr channel.
// ----------------------------------------------------------------------------
module orsft_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [orsft_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [orsft_pkg::TIME_WIDTH-1:0]      csr_data,
   output orsft_pkg::cfg_type                    cfg
);

   orsft_pkg::cfg_type cfg_ff;
   orsft_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (orsft_pkg::csr_idx_type'(csr_index))
            orsft_pkg::CSR_PULSE_HIGH:   cfg_in.pulse_high_ticks       = csr_data;
            orsft_pkg::CSR_FIRST_LATCH:  cfg_in.first_latch_low_ticks  = csr_data;
            orsft_pkg::CSR_SECOND_LATCH: cfg_in.second_latch_low_ticks = csr_data;
            orsft_pkg::CSR_ZERO_LOW:     cfg_in.zero_symbol_low_ticks  = csr_data;
            orsft_pkg::CSR_ONE_LOW:      cfg_in.one_symbol_low_ticks   = csr_data;
            orsft_pkg::CSR_REPEAT:
               cfg_in.repeat_count = csr_data[orsft_pkg::REP_WIDTH-1:0];
            orsft_pkg::CSR_GAP:          cfg_in.repeat_gap_ticks       = csr_data;
            default: ; // unused index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_high_ticks       <= orsft_pkg::PULSE_HIGH_RST;
         cfg_ff.first_latch_low_ticks  <= orsft_pkg::FIRST_LATCH_RST;
         cfg_ff.second_latch_low_ticks <= orsft_pkg::SECOND_LATCH_RST;
         cfg_ff.zero_symbol_low_ticks  <= orsft_pkg::ZERO_LOW_RST;
         cfg_ff.one_symbol_low_ticks   <= orsft_pkg::ONE_LOW_RST;
         cfg_ff.repeat_count           <= orsft_pkg::REPEAT_RST;
         cfg_ff.repeat_gap_ticks       <= orsft_pkg::GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/orsft_core.sv =====
// ----------------------------------------------------------------------------
// orsft_core
// Frame sequencer: one step per accepted request (tick or start).
// ----------------------------------------------------------------------------
module orsft_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  orsft_pkg::cfg_type                cfg,
   input  logic                              req_start,
   input  logic                              switch_on,
   input  logic [orsft_pkg::ID_WIDTH-1:0]    transmitter_id,
   input  logic [orsft_pkg::RCP_WIDTH-1:0]   recipient,
   output orsft_pkg::rsp_type                result
);

   orsft_pkg::phase_type                   phase_ff, phase_in;
   logic [orsft_pkg::FRAME_LEN-1:0]        bits_ff, bits_in;
   logic [orsft_pkg::BIDX_WIDTH-1:0]       bidx_ff, bidx_in;
   logic                                   ssym_ff, ssym_in;
   logic                                   low_ff, low_in;
   logic [orsft_pkg::COUNT_WIDTH-1:0]      dl_ff, dl_in;
   logic [orsft_pkg::REP_WIDTH-1:0]        rep_ff, rep_in;
   logic                                   level_ff, level_in;

   logic [orsft_pkg::COUNT_WIDTH-1:0]      high_len, lat1_len, lat2_len;
   logic [orsft_pkg::COUNT_WIDTH-1:0]      zero_len, one_len, gap_len, dl_dec;
   logic [orsft_pkg::REP_WIDTH-1:0]        rep_dec;
   logic [4:0]                             bit_sel;
   logic                                   symbol;
   logic                                   start_ok;
   logic                                   frame_done;
   logic                                   go_idle;

   assign high_len = orsft_pkg::clamp_len(cfg.pulse_high_ticks, 1'b0);
   assign lat1_len = orsft_pkg::clamp_len(cfg.first_latch_low_ticks, 1'b0);
   assign lat2_len = orsft_pkg::clamp_len(cfg.second_latch_low_ticks, 1'b0);
   assign zero_len = orsft_pkg::clamp_len(cfg.zero_symbol_low_ticks, 1'b0);
   assign one_len  = orsft_pkg::clamp_len(cfg.one_symbol_low_ticks, 1'b0);
   assign gap_len  = orsft_pkg::clamp_len(cfg.repeat_gap_ticks, 1'b1);
   assign rep_dec  = rep_ff - 1'b1;

   // MSB of the frame goes first; second symbol is the inverted bit
   assign bit_sel = 5'd31 - bidx_ff[4:0];
   assign symbol  = bits_ff[bit_sel] ^ ssym_ff;

   always_comb begin
      phase_in   = phase_ff;
      bits_in    = bits_ff;
      bidx_in    = bidx_ff;
      ssym_in    = ssym_ff;
      low_in     = low_ff;
      dl_in      = dl_ff;
      rep_in     = rep_ff;
      level_in   = level_ff;
      start_ok   = 1'b0;
      frame_done = 1'b0;
      go_idle    = 1'b0;
      dl_dec     = '0;

      if (req_start) begin
         if (phase_ff == orsft_pkg::PH_IDLE) begin
            bits_in  = {transmitter_id, 1'b0, switch_on, recipient};
            rep_in   = (cfg.repeat_count == '0) ? 4'd1 : cfg.repeat_count;
            bidx_in  = '0;
            ssym_in  = 1'b0;
            phase_in = orsft_pkg::PH_LATCH1;
            low_in   = 1'b0;
            level_in = 1'b1;
            dl_in    = high_len;
            start_ok = 1'b1;
         end
      end else if (phase_ff != orsft_pkg::PH_IDLE) begin
         dl_dec = (dl_ff != '0) ? dl_ff - 1'b1 : '0;
         dl_in  = dl_dec;
         if (dl_dec == '0) begin
            unique case (phase_ff)
               orsft_pkg::PH_LATCH1: begin
                  if (!low_ff) begin
                     low_in = 1'b1; level_in = 1'b0; dl_in = lat1_len;
                  end else begin
                     phase_in = orsft_pkg::PH_LATCH2;
                     low_in = 1'b0; level_in = 1'b1; dl_in = high_len;
                  end
               end
               orsft_pkg::PH_LATCH2: begin
                  if (!low_ff) begin
                     low_in = 1'b1; level_in = 1'b0; dl_in = lat2_len;
                  end else begin
                     bidx_in = '0; ssym_in = 1'b0;
                     phase_in = orsft_pkg::PH_DATA;
                     low_in = 1'b0; level_in = 1'b1; dl_in = high_len;
                  end
               end
               orsft_pkg::PH_DATA: begin
                  if (!low_ff) begin
                     low_in = 1'b1; level_in = 1'b0;
                     dl_in  = symbol ? one_len : zero_len;
                  end else if (!ssym_ff) begin
                     ssym_in = 1'b1;
                     low_in = 1'b0; level_in = 1'b1; dl_in = high_len;
                  end else begin
                     ssym_in = 1'b0;
                     bidx_in = bidx_ff + 1'b1;
                     if (bidx_in >= orsft_pkg::BIDX_WIDTH'(orsft_pkg::FRAME_LEN)) begin
                        phase_in = orsft_pkg::PH_TRAIL;
                     end
                     low_in = 1'b0; level_in = 1'b1; dl_in = high_len;
                  end
               end
               orsft_pkg::PH_TRAIL: begin
                  if (!low_ff) begin
                     low_in = 1'b1; level_in = 1'b0; dl_in = lat2_len;
                  end else if (gap_len != '0) begin
                     phase_in = orsft_pkg::PH_GAP;
                     low_in = 1'b1; level_in = 1'b0; dl_in = gap_len;
                  end else begin
                     frame_done = 1'b1;
                  end
               end
               orsft_pkg::PH_GAP: frame_done = 1'b1;
               default:           go_idle = 1'b1;
            endcase

            if (frame_done) begin
               rep_in = rep_dec;
               if (rep_dec == '0) begin
                  go_idle = 1'b1;
               end else begin
                  bidx_in = '0; ssym_in = 1'b0;
                  phase_in = orsft_pkg::PH_LATCH1;
                  low_in = 1'b0; level_in = 1'b1; dl_in = high_len;
               end
            end

            if (go_idle) begin
               phase_in = orsft_pkg::PH_IDLE;
               low_in   = 1'b0;
               level_in = 1'b0;
               dl_in    = '0;
               rep_in   = '0;
               bidx_in  = '0;
               ssym_in  = 1'b0;
            end
         end
      end
   end

   assign result.tx_level       = level_in;
   assign result.busy_res       = (phase_in != orsft_pkg::PH_IDLE);
   assign result.start_accepted = start_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= orsft_pkg::PH_IDLE;
         bits_ff  <= '0;
         bidx_ff  <= '0;
         ssym_ff  <= 1'b0;
         low_ff   <= 1'b0;
         dl_ff    <= '0;
         rep_ff   <= '0;
         level_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         bidx_ff  <= bidx_in;
         ssym_ff  <= ssym_in;
         low_ff   <= low_in;
         dl_ff    <= dl_in;
         rep_ff   <= rep_in;
         level_ff <= level_in;
      end
   end

   // Carrier is on exactly during the high part of an active segment
   a_level_high_part: assert property (@(posedge clock) disable iff (reset)
      level_ff == (phase_ff != orsft_pkg::PH_IDLE && !low_ff))
      else $error("level out of step with segment state");

   a_repeats_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != orsft_pkg::PH_IDLE |-> rep_ff != '0)
      else $error("busy with no repeats left");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bidx_ff <= orsft_pkg::BIDX_WIDTH'(orsft_pkg::FRAME_LEN))
      else $error("bit index past frame end");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == orsft_pkg::PH_IDLE |-> dl_ff == '0)
      else $error("idle with duration pending");

endmodule

// ===== hdl/orsft_skid.sv =====
// ----------------------------------------------------------------------------
// orsft_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module orsft_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_fire,
   input  orsft_pkg::rsp_type   in_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output orsft_pkg::rsp_type   rsp_data
);

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   orsft_pkg::rsp_type main_ff, main_in;
   orsft_pkg::rsp_type skid_ff, skid_in;
   logic               out_fire;

   assign out_fire  = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff) begin
         if (in_fire && out_fire) begin
            main_in = in_data;
         end else if (in_fire) begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end else if (out_fire) begin
            main_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         main_in       = in_data;
         main_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without output entry");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_fire)
      else $error("request taken with buffer full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_fire |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on drain");

endmodule

// ===== hdl/ook_remote_switch_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_transmitter
// OOK keyer for the self-learning remote-switch frame protocol.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one request per cycle at most; req_type 0 is a 1 us tick,
//    1 is a start carrying switch_on, transmitter_id and recipient. A start
//    while a frame sequence is running is dropped (rsp_start_accepted = 0).
//  - rsp channel: exactly one response per request, giving the keyed level,
//    busy flag and start-taken flag as they stand after that request.
//  - csr channel: index 0..6 selects a timing/repeat register; csr_ready is
//    always high. Write only while no request is outstanding.
//  - A response is registered into the output register, or into the skid
//    register behind a stalled one. Throughput: one request per cycle while
//    req_stall is low; the sequencer step is combinational logic.
//  - A two-entry response buffer decouples the sides: requests keep flowing
//    while one response waits; req_stall rises only when both entries are
//    held by a stalled receiver.
//  - Reset (synchronous): sequencer idle, level low, registers to defaults,
//    response buffer empty.
// ----------------------------------------------------------------------------
module ook_remote_switch_frame_transmitter (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic                                  req_switch_on,
   input  logic [orsft_pkg::ID_WIDTH-1:0]        req_transmitter_id,
   input  logic [orsft_pkg::RCP_WIDTH-1:0]       req_recipient,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_tx_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_start_accepted,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [orsft_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [orsft_pkg::TIME_WIDTH-1:0]      csr_data
);

   orsft_pkg::cfg_type cfg;
   orsft_pkg::rsp_type core_rsp;
   orsft_pkg::rsp_type out_rsp;
   logic               buf_full;
   logic               req_fire;

   assign req_stall = buf_full;
   assign req_fire  = req_valid && !buf_full;

   orsft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   orsft_core u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .cfg            (cfg),
      .req_start      (req_type),
      .switch_on      (req_switch_on),
      .transmitter_id (req_transmitter_id),
      .recipient      (req_recipient),
      .result         (core_rsp)
   );

   orsft_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (req_fire),
      .in_data   (core_rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (out_rsp)
   );

   assign rsp_tx_level       = out_rsp.tx_level;
   assign rsp_busy_res       = out_rsp.busy_res;
   assign rsp_start_accepted = out_rsp.start_accepted;

endmodule

// ===== tb/sv/tb_ook_remote_switch_frame_transmitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ook_remote_switch_frame_transmitter
// Self-checking bench for the OOK remote-switch frame keyer. Drives start and
// tick requests, predicts the keyed level, busy flag and start-taken flag of
// every response, and compares responses in order. Timing registers are
// reprogrammed between frames, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ook_remote_switch_frame_transmitter;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;
   localparam int   RANDOM_PHASES = 4;
   localparam int   PHASE_ITEMS   = 120;
   localparam int   MAX_PRINTED   = 30;

   // Frame keyer predictor plus the queue of responses still owed.
   class ook_frame_scoreboard;
      orsft_pkg::cfg_type                     cfg;
      orsft_pkg::phase_type                   phase;
      logic [31:0]                            frame_word;
      logic [5:0]                             bit_pos;
      logic                                   second_half;
      logic                                   low_part;
      logic                                   level;
      logic [orsft_pkg::COUNT_WIDTH-1:0]      ticks_left;
      logic [orsft_pkg::REP_WIDTH-1:0]        frames_left;
      orsft_pkg::rsp_type                     expected_levels[$];
      int                                     fail_count;
      int                                     rsp_count;

      function new();
         cfg.pulse_high_ticks       = orsft_pkg::PULSE_HIGH_RST;
         cfg.first_latch_low_ticks  = orsft_pkg::FIRST_LATCH_RST;
         cfg.second_latch_low_ticks = orsft_pkg::SECOND_LATCH_RST;
         cfg.zero_symbol_low_ticks  = orsft_pkg::ZERO_LOW_RST;
         cfg.one_symbol_low_ticks   = orsft_pkg::ONE_LOW_RST;
         cfg.repeat_count           = orsft_pkg::REPEAT_RST;
         cfg.repeat_gap_ticks       = orsft_pkg::GAP_RST;
         frame_word = '0;
         fail_count = 0;
         rsp_count  = 0;
         go_idle();
      endfunction

      task report(input string msg);
         fail_count++;
         if (fail_count <= MAX_PRINTED) begin
            $display("%0t ERROR: %s", $time, msg);
         end
      endtask

      function void set_reg(input orsft_pkg::csr_idx_type idx,
                            input logic [orsft_pkg::TIME_WIDTH-1:0] data);
         case (idx)
            orsft_pkg::CSR_PULSE_HIGH:   cfg.pulse_high_ticks       = data;
            orsft_pkg::CSR_FIRST_LATCH:  cfg.first_latch_low_ticks  = data;
            orsft_pkg::CSR_SECOND_LATCH: cfg.second_latch_low_ticks = data;
            orsft_pkg::CSR_ZERO_LOW:     cfg.zero_symbol_low_ticks  = data;
            orsft_pkg::CSR_ONE_LOW:      cfg.one_symbol_low_ticks   = data;
            orsft_pkg::CSR_REPEAT:
               cfg.repeat_count = data[orsft_pkg::REP_WIDTH-1:0];
            orsft_pkg::CSR_GAP:          cfg.repeat_gap_ticks       = data;
            default: ;
         endcase
      endfunction

      // zero means one tick unless a zero length is allowed; clip to counter
      function logic [orsft_pkg::COUNT_WIDTH-1:0] segment_ticks(
            input logic [orsft_pkg::TIME_WIDTH-1:0] v, input bit zero_ok);
         logic [31:0] n;
         n = 32'(v);
         if (n == 0 && !zero_ok) n = 32'd1;
         if (n > (32'd1 << orsft_pkg::COUNT_WIDTH) - 32'd1)
            n = (32'd1 << orsft_pkg::COUNT_WIDTH) - 32'd1;
         return n[orsft_pkg::COUNT_WIDTH-1:0];
      endfunction

      function void go_idle();
         phase       = orsft_pkg::PH_IDLE;
         low_part    = 1'b0;
         level       = 1'b0;
         ticks_left  = '0;
         frames_left = '0;
         bit_pos     = '0;
         second_half = 1'b0;
      endfunction

      function void load_high(input orsft_pkg::phase_type p);
         phase      = p;
         low_part   = 1'b0;
         level      = 1'b1;
         ticks_left = segment_ticks(cfg.pulse_high_ticks, 1'b0);
      endfunction

      function void load_low(input logic [orsft_pkg::TIME_WIDTH-1:0] len);
         low_part   = 1'b1;
         level      = 1'b0;
         ticks_left = segment_ticks(len, 1'b0);
      endfunction

      function void end_of_frame();
         frames_left = frames_left - 1'b1;
         if (frames_left == 0) begin
            go_idle();
         end else begin
            bit_pos     = '0;
            second_half = 1'b0;
            load_high(orsft_pkg::PH_LATCH1);
         end
      endfunction

      // Manchester: second half of a bit carries the inverted symbol
      function logic current_symbol();
         logic b;
         b = frame_word[orsft_pkg::FRAME_LEN - 1 - bit_pos[4:0]];
         return second_half ? ~b : b;
      endfunction

      function void next_segment();
         case (phase)
            orsft_pkg::PH_LATCH1: begin
               if (!low_part) load_low(cfg.first_latch_low_ticks);
               else load_high(orsft_pkg::PH_LATCH2);
            end
            orsft_pkg::PH_LATCH2: begin
               if (!low_part) begin
                  load_low(cfg.second_latch_low_ticks);
               end else begin
                  bit_pos     = '0;
                  second_half = 1'b0;
                  load_high(orsft_pkg::PH_DATA);
               end
            end
            orsft_pkg::PH_DATA: begin
               if (!low_part) begin
                  load_low(current_symbol() ? cfg.one_symbol_low_ticks
                                            : cfg.zero_symbol_low_ticks);
               end else if (!second_half) begin
                  second_half = 1'b1;
                  load_high(orsft_pkg::PH_DATA);
               end else begin
                  second_half = 1'b0;
                  bit_pos     = bit_pos + 1'b1;
                  if (bit_pos >= orsft_pkg::FRAME_LEN) load_high(orsft_pkg::PH_TRAIL);
                  else load_high(orsft_pkg::PH_DATA);
               end
            end
            orsft_pkg::PH_TRAIL: begin
               if (!low_part) begin
                  load_low(cfg.second_latch_low_ticks);
               end else if (segment_ticks(cfg.repeat_gap_ticks, 1'b1) != 0) begin
                  phase      = orsft_pkg::PH_GAP;
                  low_part   = 1'b1;
                  level      = 1'b0;
                  ticks_left = segment_ticks(cfg.repeat_gap_ticks, 1'b1);
               end else begin
                  end_of_frame();
               end
            end
            orsft_pkg::PH_GAP: end_of_frame();
            default: go_idle();
         endcase
      endfunction

      function void note_request(input logic typ, input logic on,
                                 input logic [orsft_pkg::ID_WIDTH-1:0] id,
                                 input logic [orsft_pkg::RCP_WIDTH-1:0] rcp);
         orsft_pkg::rsp_type exp;
         logic               taken;
         taken = 1'b0;
         if (typ == REQ_START) begin
            if (phase == orsft_pkg::PH_IDLE) begin
               frame_word  = {id, 1'b0, on, rcp};
               frames_left = (cfg.repeat_count == 0) ? 4'd1 : cfg.repeat_count;
               bit_pos     = '0;
               second_half = 1'b0;
               load_high(orsft_pkg::PH_LATCH1);
               taken = 1'b1;
            end
         end else if (phase != orsft_pkg::PH_IDLE) begin
            if (ticks_left > 0) ticks_left = ticks_left - 1'b1;
            if (ticks_left == 0) next_segment();
         end
         exp.tx_level       = level;
         exp.busy_res       = (phase != orsft_pkg::PH_IDLE);
         exp.start_accepted = taken;
         expected_levels.push_back(exp);
      endfunction

      task check_response(input orsft_pkg::rsp_type got);
         orsft_pkg::rsp_type exp;
         rsp_count++;
         if (expected_levels.size() == 0) begin
            report($sformatf("response %0d arrived with no request outstanding",
                             rsp_count));
         end else begin
            exp = expected_levels.pop_front();
            if (got.tx_level !== exp.tx_level)
               report($sformatf("response %0d tx_level %b, expected %b",
                                rsp_count, got.tx_level, exp.tx_level));
            if (got.busy_res !== exp.busy_res)
               report($sformatf("response %0d busy_res %b, expected %b",
                                rsp_count, got.busy_res, exp.busy_res));
            if (got.start_accepted !== exp.start_accepted)
               report($sformatf("response %0d start_accepted %b, expected %b",
                                rsp_count, got.start_accepted, exp.start_accepted));
         end
      endtask

      function int pending();
         return expected_levels.size();
      endfunction

      function bit busy();
         return phase != orsft_pkg::PH_IDLE;
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_type;
   logic                                  req_switch_on;
   logic [orsft_pkg::ID_WIDTH-1:0]        req_transmitter_id;
   logic [orsft_pkg::RCP_WIDTH-1:0]       req_recipient;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic                                  rsp_tx_level;
   logic                                  rsp_busy_res;
   logic                                  rsp_start_accepted;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [orsft_pkg::CSR_IDX_WIDTH-1:0]   csr_index;
   logic [orsft_pkg::TIME_WIDTH-1:0]      csr_data;

   ook_frame_scoreboard sb;
   int src_idle_pct;
   int sink_stall_pct;
   int hold_cycles;
   int random_items;

   ook_remote_switch_frame_transmitter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_switch_on      (req_switch_on),
      .req_transmitter_id (req_transmitter_id),
      .req_recipient      (req_recipient),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tx_level       (rsp_tx_level),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_start_accepted (rsp_start_accepted),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb_ook_remote_switch_frame_transmitter: FAIL");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
         end
      end
   end

   // Responses are sampled at the edge, before this edge's updates land.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_response('{rsp_tx_level, rsp_busy_res, rsp_start_accepted});
         end
      end
   end

   task automatic send_req(input logic typ, input logic on,
                           input logic [orsft_pkg::ID_WIDTH-1:0] id,
                           input logic [orsft_pkg::RCP_WIDTH-1:0] rcp);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= typ;
      req_switch_on      <= on;
      req_transmitter_id <= id;
      req_recipient      <= rcp;
      do @(posedge clock); while (req_stall);
      sb.note_request(typ, on, id, rcp);
   endtask

   task automatic send_tick();
      send_req(REQ_TICK, 1'($urandom), orsft_pkg::ID_WIDTH'($urandom),
               orsft_pkg::RCP_WIDTH'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input orsft_pkg::csr_idx_type idx,
                            input logic [orsft_pkg::TIME_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   // Only called with the keyer idle; upper bits of the repeat write are junk.
   task automatic configure(input logic [orsft_pkg::TIME_WIDTH-1:0] high_t, first_t,
                            input logic [orsft_pkg::TIME_WIDTH-1:0] second_t,
                            input logic [orsft_pkg::TIME_WIDTH-1:0] zero_t, one_t,
                            input logic [orsft_pkg::REP_WIDTH-1:0] reps,
                            input logic [orsft_pkg::TIME_WIDTH-1:0] gap_t);
      wait_drained();
      write_reg(orsft_pkg::CSR_PULSE_HIGH, high_t);
      write_reg(orsft_pkg::CSR_FIRST_LATCH, first_t);
      write_reg(orsft_pkg::CSR_SECOND_LATCH, second_t);
      write_reg(orsft_pkg::CSR_ZERO_LOW, zero_t);
      write_reg(orsft_pkg::CSR_ONE_LOW, one_t);
      write_reg(orsft_pkg::CSR_REPEAT, {12'($urandom), reps});
      write_reg(orsft_pkg::CSR_GAP, gap_t);
      csr_valid <= 1'b0;
   endtask

   // Tick until the sequence ends; noisy mode mixes in starts that get dropped.
   task automatic finish_frame(input bit noisy, input int pause_at);
      int ticks;
      ticks = 0;
      while (sb.busy()) begin
         if (noisy && $urandom_range(0, 99) < 2) begin
            send_req(REQ_START, 1'($urandom), orsft_pkg::ID_WIDTH'($urandom),
                     orsft_pkg::RCP_WIDTH'($urandom));
         end else begin
            if (ticks == pause_at) wait_drained();
            send_tick();
            ticks++;
            random_items++;
         end
      end
   endtask

   task automatic run_frame(input logic on, input logic [orsft_pkg::ID_WIDTH-1:0] id,
                            input logic [orsft_pkg::RCP_WIDTH-1:0] rcp, input bit noisy,
                            input int pause_at);
      send_req(REQ_START, on, id, rcp);
      random_items++;
      finish_frame(noisy, pause_at);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
         1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
         default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
   endtask

   initial begin
      int phase_start;
      sb = new();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_cycles    = 0;
      random_items   = 0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_type           <= REQ_TICK;
      req_switch_on      <= 1'b0;
      req_transmitter_id <= '0;
      req_recipient      <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= orsft_pkg::CSR_PULSE_HIGH;
      csr_data           <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ticks with nothing running
      send_tick();
      send_tick();

      // frame with all-ones ID, switch bit and recipient, a start while busy, then the rest of the sequence
      configure(16'd1, 16'd2, 16'd1, 16'd1, 16'd2, 4'd2, 16'd3);
      send_req(REQ_START, 1'b1, '1, '1);
      send_req(REQ_START, 1'b0, '0, '0);
      finish_frame(1'b0, -1);
      send_tick();

      // zero lengths become one tick, zero gap is skipped, zero repeats is one
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 16'd0);
      run_frame(1'b0, '0, '0, 1'b0, -1);
      send_tick();

      random_items = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 4'($urandom_range(0, 1)),
                   16'($urandom_range(0, 5)));
         set_idling(p % 4);
         // receiver holds off while requests keep coming, so the input backs up
         if (p == 0) hold_cycles = 64;
         phase_start = random_items;
         while (random_items - phase_start < PHASE_ITEMS) begin
            repeat ($urandom_range(0, 2)) send_tick();
            run_frame(1'($urandom), orsft_pkg::ID_WIDTH'($urandom),
                      orsft_pkg::RCP_WIDTH'($urandom), 1'b1, (p == 1) ? 50 : -1);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("tb_ook_remote_switch_frame_transmitter: PASS");
      end else begin
         $display("tb_ook_remote_switch_frame_transmitter: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/orsft_pkg.sv
hdl/orsft_csr.sv
hdl/orsft_core.sv
hdl/orsft_skid.sv
hdl/ook_remote_switch_frame_transmitter.sv
tb/sv/tb_ook_remote_switch_frame_transmitter.sv
